// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the framer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock, masked while reset is high
`define MPRGF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("framer check failed");

// property checked on every rising clock, reset included
`define MPRGF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("framer check failed");

`endif

// ===== hw/rtl/mprgf_pkg.sv =====
// ----------------------------------------------------------------------------
// mprgf package
// shared types and constants of the multi-port gap framer
// ----------------------------------------------------------------------------
package mprgf_pkg;

   // bus widths
   localparam int CFG_W       = 16;
   localparam int PORT_W      = 2;
   localparam int BYTE_W      = 8;
   localparam int MASK_W      = 4;
   localparam int INDEX_W     = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // register reset values
   localparam logic [CFG_W-1:0]  OCTET_GAP_RST     = 16'd4;
   localparam logic [CFG_W-1:0]  SESSION_GAP_RST   = 16'd1000;
   localparam logic [CFG_W-1:0]  RADIO_GAP_RST     = 16'd2000;
   localparam logic [CFG_W-1:0]  FRAME_END_RST     = 16'd4;
   localparam logic [CFG_W-1:0]  TX_LIMIT_RST      = 16'd500;
   localparam logic [PORT_W-1:0] RADIO_PORT_RST    = 2'd0;

   // request opcodes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_RX_BYTE = 2'd1,
      OP_TX_DONE = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   // register word index
   typedef enum logic [2:0] {
      REG_OCTET_GAP   = 3'd0,
      REG_SESSION_GAP = 3'd1,
      REG_RADIO_GAP   = 3'd2,
      REG_FRAME_END   = 3'd3,
      REG_TX_LIMIT    = 3'd4,
      REG_RADIO_PORT  = 3'd5
   } reg_index_type;

   // classified command kind
   typedef enum logic [3:0] {
      CMD_NONE = 4'b0001,
      CMD_TICK = 4'b0010,
      CMD_BYTE = 4'b0100,
      CMD_TX   = 4'b1000
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [PORT_W-1:0]   port;
      logic [BYTE_W-1:0]   rx_byte;
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0]    octet_gap;
      logic [CFG_W-1:0]    session_gap;
      logic [CFG_W-1:0]    radio_gap;
      logic [CFG_W-1:0]    frame_end;
      logic [CFG_W-1:0]    tx_limit;
      logic [PORT_W-1:0]   radio_port;
   } cfg_type;

   // result fields, stored in the lowest bit
   typedef struct packed {
      logic                tx_done;
      logic [MASK_W-1:0]   tx_limit_mask;
      logic [MASK_W-1:0]   frame_end_mask;
      logic [INDEX_W-1:0]  byte_index;
      logic                session_reset;
      logic                frame_restart;
      logic                overflow_drop;
      logic                stored;
   } rsp_type;

   // queue occupancy, request side
   typedef struct packed {
      logic                not_full;
      logic                not_empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/mprgf_ram.sv =====
// ----------------------------------------------------------------------------
// mprgf ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mprgf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mprgf_front.sv =====
// ----------------------------------------------------------------------------
// mprgf front
// accepts request transfers and classifies them into commands
// ----------------------------------------------------------------------------
module mprgf_front
   import mprgf_pkg::*;
#(
   parameter int PORTS = 4
) (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic [REQ_TUSER_W-1:0]  req_tuser,
   input  queue_status_type        queue_status,
   output logic                    push,
   output cmd_type                 cmd
);

   opcode_type        opcode;
   logic [PORT_W-1:0] port;
   logic              port_ok;

   assign opcode  = opcode_type'(req_tuser);
   assign port    = req_tdata[PORT_W-1:0];
   assign port_ok = (32'(port) < PORTS);

   // classify; a byte or completion for an absent port does nothing
   always_comb begin
      cmd.port    = port;
      cmd.rx_byte = req_tdata[PORT_W +: BYTE_W];
      case (opcode)
         OP_TICK:    cmd.kind = CMD_TICK;
         OP_RX_BYTE: cmd.kind = port_ok ? CMD_BYTE : CMD_NONE;
         OP_TX_DONE: cmd.kind = port_ok ? CMD_TX : CMD_NONE;
         default:    cmd.kind = CMD_NONE;
      endcase
   end

   assign req_tready = queue_status.not_full;
   assign push       = req_tvalid & queue_status.not_full;

endmodule

// ===== hw/rtl/mprgf_queue.sv =====
// ----------------------------------------------------------------------------
// mprgf queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module mprgf_queue
   import mprgf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmd_type           push_cmd,
   input  logic              pop,
   output cmd_type           head,
   output queue_status_type  status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_full  = (32'(count_ff) < QUEUE_DEPTH);
   assign status.not_empty = (count_ff != '0);

endmodule

// ===== hw/rtl/mprgf_back.sv =====
// ----------------------------------------------------------------------------
// mprgf back
// per-port counters, buffer append and the result register
// ----------------------------------------------------------------------------
module mprgf_back
   import mprgf_pkg::*;
#(
   parameter int PORTS        = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  cmd_type                 cmd,
   input  logic                    cmd_valid,
   output logic                    cmd_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int PI_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
   localparam int DEPTH  = PORTS * BUFFER_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CFG_W-1:0] idle_ff  [PORTS];
   logic [CFG_W-1:0] idle_in  [PORTS];
   logic [CFG_W-1:0] quiet_ff [PORTS];
   logic [CFG_W-1:0] quiet_in [PORTS];
   logic [CFG_W-1:0] tx_ff    [PORTS];
   logic [CFG_W-1:0] tx_in    [PORTS];
   logic [LEN_W-1:0] len_ff   [PORTS];
   logic [LEN_W-1:0] len_in   [PORTS];

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [PI_W-1:0]   pi;
   logic [CFG_W-1:0]  session_limit;
   logic              take;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   assign pi            = cmd.port[PI_W-1:0];
   assign session_limit = (cmd.port == cfg.radio_port) ? cfg.radio_gap : cfg.session_gap;
   assign take          = cmd_valid & (~rsp_valid_ff | rsp_tready);
   assign cmd_pop       = take;
   assign wr_addr       = ADDR_W'(32'(pi) * BUFFER_BYTES) + ADDR_W'(len_ff[pi]);

   // next state of the per-port counters and the result
   always_comb begin
      idle_in  = idle_ff;
      quiet_in = quiet_ff;
      tx_in    = tx_ff;
      len_in   = len_ff;
      rsp_in   = '0;
      wr_en    = 1'b0;
      if (take) begin
         case (cmd.kind)
            CMD_TICK: begin
               for (int i = 0; i < PORTS; i++) begin
                  if (idle_ff[i] < cfg.radio_gap) idle_in[i] = idle_ff[i] + 1'b1;
                  if (tx_ff[i] < cfg.tx_limit) tx_in[i] = tx_ff[i] + 1'b1;
                  if (quiet_ff[i] < cfg.frame_end) quiet_in[i] = quiet_ff[i] + 1'b1;
               end
            end
            CMD_BYTE: begin
               quiet_in[pi] = '0;
               idle_in[pi]  = '0;
               if (idle_ff[pi] >= cfg.octet_gap) begin
                  rsp_in.frame_restart = 1'b1;
                  rsp_in.session_reset = (idle_ff[pi] >= session_limit);
               end
               if (len_ff[pi] < LEN_W'(BUFFER_BYTES)) begin
                  wr_en             = 1'b1;
                  rsp_in.stored     = 1'b1;
                  rsp_in.byte_index = INDEX_W'(len_ff[pi]);
                  len_in[pi]        = len_ff[pi] + 1'b1;
               end else begin
                  rsp_in.overflow_drop = 1'b1;
                  len_in[pi]           = '0;
               end
            end
            CMD_TX: begin
               tx_in[pi]      = '0;
               rsp_in.tx_done = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // masks after the step, absent ports read as zero
      for (int i = 0; i < MASK_W; i++) begin
         if (i < PORTS) begin
            rsp_in.frame_end_mask[i] = (quiet_in[i] >= cfg.frame_end);
            rsp_in.tx_limit_mask[i]  = (tx_in[i] >= cfg.tx_limit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS; i++) begin
            idle_ff[i]  <= '0;
            quiet_ff[i] <= '0;
            tx_ff[i]    <= '0;
            len_ff[i]   <= '0;
         end
      end else begin
         idle_ff  <= idle_in;
         quiet_ff <= quiet_in;
         tx_ff    <= tx_in;
         len_ff   <= len_in;
      end
   end

   // result register, holds while the receiver stalls
   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // receive buffers of all ports, one region per port
   mprgf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.rx_byte),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

endmodule

// ===== hw/rtl/multi_port_rx_gap_framer_top.sv =====
// ----------------------------------------------------------------------------
// multi-port rx gap framer
// serial receive framer that marks frames and sessions by line silence
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries ticks, received bytes and transmit completions
//   (tuser = opcode, tdata = port, rx_byte). Every request transfer gives
//   exactly one rsp transfer with the per-byte flags, buffer index and the
//   frame-end and transmit-limit masks of all ports.
//   Path: a request passes the command queue, then the result register,
//   before rsp_tvalid rises; a receiver stall can hold it in the queue.
//   Throughput: one request per cycle while the receiver does not stall;
//   all ports' counters update together in the back end and a byte costs one write on the store port.
//   The csr port writes the thresholds and the radio port index; writes
//   are meant for when no request is in flight.
//   Reset clears all counters and buffer lengths and loads the default
//   thresholds; buffer contents are not cleared, so no start-up pass.
//   When the receiver stalls, the result register holds, the two-entry
//   command queue fills, and req_tready falls once it is full.
// ----------------------------------------------------------------------------
module multi_port_rx_gap_framer_top
   import mprgf_pkg::*;
#(
   parameter int PORTS        = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   // request: tdata = port[1:0], rx_byte[9:2], zero pad
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // request: tuser = opcode[1:0]
   input  logic [REQ_TUSER_W-1:0]  req_tuser,
   // result: tdata = stored, overflow_drop, frame_restart, session_reset,
   // byte_index[11:4], frame_end_mask[15:12], tx_limit_mask[19:16],
   // tx_done[20], zero pad
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // register port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   reg_index_type    reg_index;
   logic             csr_write;
   queue_status_type queue_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_OCTET_GAP:   cfg_in.octet_gap   = csr_pwdata[CFG_W-1:0];
            REG_SESSION_GAP: cfg_in.session_gap = csr_pwdata[CFG_W-1:0];
            REG_RADIO_GAP:   cfg_in.radio_gap   = csr_pwdata[CFG_W-1:0];
            REG_FRAME_END:   cfg_in.frame_end   = csr_pwdata[CFG_W-1:0];
            REG_TX_LIMIT:    cfg_in.tx_limit    = csr_pwdata[CFG_W-1:0];
            REG_RADIO_PORT:  cfg_in.radio_port  = csr_pwdata[PORT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octet_gap   <= OCTET_GAP_RST;
         cfg_ff.session_gap <= SESSION_GAP_RST;
         cfg_ff.radio_gap   <= RADIO_GAP_RST;
         cfg_ff.frame_end   <= FRAME_END_RST;
         cfg_ff.tx_limit    <= TX_LIMIT_RST;
         cfg_ff.radio_port  <= RADIO_PORT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (reg_index)
         REG_OCTET_GAP:   csr_prdata = CSR_DATA_W'(cfg_ff.octet_gap);
         REG_SESSION_GAP: csr_prdata = CSR_DATA_W'(cfg_ff.session_gap);
         REG_RADIO_GAP:   csr_prdata = CSR_DATA_W'(cfg_ff.radio_gap);
         REG_FRAME_END:   csr_prdata = CSR_DATA_W'(cfg_ff.frame_end);
         REG_TX_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.tx_limit);
         REG_RADIO_PORT:  csr_prdata = CSR_DATA_W'(cfg_ff.radio_port);
         default:         csr_prdata = '0;
      endcase
   end

   mprgf_front #(
      .PORTS (PORTS)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .cmd          (push_cmd)
   );

   mprgf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .status   (queue_status)
   );

   mprgf_back #(
      .PORTS        (PORTS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (head_cmd),
      .cmd_valid  (queue_status.not_empty),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/mprgf_checker.sv =====
// ----------------------------------------------------------------------------
// mprgf checker
// port-level checks of the framer result stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mprgf_checker
   import mprgf_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   rsp_type rsp;

   assign rsp = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);

   // a stalled result holds its value
   `MPRGF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // session reset only together with a new frame
   `MPRGF_ASSERT(a_session_needs_frame, clock, reset, rsp_tvalid && rsp.session_reset |-> rsp.frame_restart)

   // a byte is either stored or dropped, never both
   `MPRGF_ASSERT(a_store_or_drop, clock, reset, rsp_tvalid |-> !(rsp.stored && rsp.overflow_drop))

   // a transmit completion carries no byte flags
   `MPRGF_ASSERT(a_tx_no_byte, clock, reset, rsp_tvalid && rsp.tx_done |-> !rsp.stored && !rsp.overflow_drop && !rsp.frame_restart)

   // nothing is presented in the cycle after a reset cycle
   `MPRGF_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind multi_port_rx_gap_framer_top mprgf_checker u_mprgf_checker (.*);

// ===== dv/multi_port_rx_gap_framer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi-port rx gap framer testbench
// drives ticks, received bytes and transmit completions through the request
// stream and checks every result transfer against a cycle-free model of the
// per-port idle, quiet and transmit counters and the receive buffer lengths;
// walks a short directed table, then framed random traffic over several
// threshold settings, with bursty sender and a stalling receiver
// ----------------------------------------------------------------------------
module multi_port_rx_gap_framer_top_tb;
   import mprgf_pkg::*;

   localparam int PORTS        = 4;
   localparam int BUFFER_BYTES = 256;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int N_DIRECTED   = 25;

   // fixed register settings used by the directed table
   localparam int S_DEFAULT = 0;
   localparam int S_ONES    = 1;
   localparam int S_ZEROS   = 2;
   localparam int S_MAX     = 3;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PERIODIC,
      READY_RARELY
   } ready_pattern_type;

   typedef struct {
      int          setting;
      opcode_type  op;
      logic [1:0]  port;
      logic [7:0]  data;
      bit          typed;
      rsp_type     rsp;
   } directed_row_type;

   // dut ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // framer model state
   cfg_type     model_cfg = '{OCTET_GAP_RST, SESSION_GAP_RST, RADIO_GAP_RST,
                              FRAME_END_RST, TX_LIMIT_RST, RADIO_PORT_RST};
   logic [15:0] idle_cnt  [PORTS] = '{default: '0};
   logic [15:0] quiet_cnt [PORTS] = '{default: '0};
   logic [15:0] tx_cnt    [PORTS] = '{default: '0};
   int          rx_len    [PORTS] = '{default: 0};

   rsp_type     expected_rsp_q [$];

   // run bookkeeping
   int          cycle_count = 0;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          results_seen = 0;
   int          settings_applied = 0;
   int          bytes_stored = 0;
   int          drops_seen = 0;
   int          frame_starts = 0;
   int          session_starts = 0;
   int          tx_pulses = 0;
   int          burst_left = 1;
   int          stall_left = 0;
   ready_pattern_type stall_mode = READY_ALWAYS;
   rsp_type     mon_got;
   rsp_type     mon_want;

   cfg_type          fixed_settings [4];
   directed_row_type directed_rows [N_DIRECTED];

   multi_port_rx_gap_framer_top #(
      .PORTS        (PORTS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $realtime,
                  expected_rsp_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic rsp_type make_result(input logic stored, input logic drop,
                                           input logic frame_start,
                                           input logic session_start,
                                           input logic [7:0] index,
                                           input logic [3:0] frame_mask,
                                           input logic [3:0] tx_mask,
                                           input logic tx_pulse);
      rsp_type r;
      r.stored         = stored;
      r.overflow_drop  = drop;
      r.frame_restart  = frame_start;
      r.session_reset  = session_start;
      r.byte_index     = index;
      r.frame_end_mask = frame_mask;
      r.tx_limit_mask  = tx_mask;
      r.tx_done        = tx_pulse;
      return r;
   endfunction

   // advance the framer model by one request and give its result
   function automatic rsp_type predict_framer(input opcode_type op,
                                              input logic [1:0] port);
      rsp_type     r;
      logic [15:0] session_limit;
      r = '0;
      case (op)
         OP_TICK: begin
            for (int i = 0; i < PORTS; i++) begin
               if (idle_cnt[i] < model_cfg.radio_gap) idle_cnt[i] = idle_cnt[i] + 1'b1;
               if (tx_cnt[i] < model_cfg.tx_limit) tx_cnt[i] = tx_cnt[i] + 1'b1;
               if (quiet_cnt[i] < model_cfg.frame_end) quiet_cnt[i] = quiet_cnt[i] + 1'b1;
            end
         end
         OP_RX_BYTE: begin
            if (port < PORTS) begin
               session_limit = (port == model_cfg.radio_port) ? model_cfg.radio_gap
                                                              : model_cfg.session_gap;
               quiet_cnt[port] = '0;
               if (idle_cnt[port] >= model_cfg.octet_gap) begin
                  r.frame_restart = 1'b1;
                  if (idle_cnt[port] >= session_limit) r.session_reset = 1'b1;
               end
               idle_cnt[port] = '0;
               if (rx_len[port] < BUFFER_BYTES) begin
                  r.stored     = 1'b1;
                  r.byte_index = 8'(rx_len[port]);
                  rx_len[port] = rx_len[port] + 1;
               end else begin
                  r.overflow_drop = 1'b1;
                  rx_len[port]    = 0;
               end
            end
         end
         OP_TX_DONE: begin
            if (port < PORTS) begin
               tx_cnt[port] = '0;
               r.tx_done    = 1'b1;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < PORTS; i++) begin
         if (quiet_cnt[i] >= model_cfg.frame_end) r.frame_end_mask[i] = 1'b1;
         if (tx_cnt[i] >= model_cfg.tx_limit) r.tx_limit_mask[i] = 1'b1;
      end
      return r;
   endfunction

   // one request transfer, then a gap once the current burst runs out
   task automatic issue_request(input opcode_type op, input logic [1:0] port,
                                input logic [7:0] data, input bit typed,
                                input rsp_type typed_rsp);
      rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, data, port};
      do @(posedge clock); while (!req_tready);
      predicted = predict_framer(op, port);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // stop sending and let the pipeline empty
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      write_reg(REG_OCTET_GAP, 32'(s.octet_gap));
      write_reg(REG_SESSION_GAP, 32'(s.session_gap));
      write_reg(REG_RADIO_GAP, 32'(s.radio_gap));
      write_reg(REG_FRAME_END, 32'(s.frame_end));
      write_reg(REG_TX_LIMIT, 32'(s.tx_limit));
      write_reg(REG_RADIO_PORT, 32'(s.radio_port));
      model_cfg = s;
      settings_applied++;
   endtask

   // small thresholds so that every gap class is reached in a few ticks
   function automatic cfg_type random_settings();
      cfg_type s;
      s.octet_gap   = 16'($urandom_range(1, 12));
      s.session_gap = 16'($urandom_range(1, 40));
      s.radio_gap   = 16'($urandom_range(1, 40));
      s.frame_end   = 16'($urandom_range(1, 16));
      s.tx_limit    = 16'($urandom_range(1, 60));
      s.radio_port  = 2'($urandom_range(0, 3));
      return s;
   endfunction

   // frames of silence then bytes, mixed with completions and noise
   task automatic run_traffic(input int item_goal, input int max_gap);
      int         sent;
      int         kind;
      int         n_ticks;
      int         n_bytes;
      logic [1:0] frame_port;
      sent = 0;
      while (sent < item_goal) begin
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            // broken sequence: anything on any port
            repeat ($urandom_range(1, 8)) begin
               issue_request(opcode_type'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             8'($urandom), 1'b0, '0);
               sent++;
            end
         end else if (kind < 5) begin
            issue_request(OP_TX_DONE, 2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
            sent++;
         end else begin
            n_ticks    = $urandom_range(0, max_gap);
            n_bytes    = $urandom_range(1, 16);
            frame_port = 2'($urandom_range(0, 3));
            repeat (n_ticks) issue_request(OP_TICK, 2'($urandom_range(0, 3)),
                                           8'($urandom), 1'b0, '0);
            repeat (n_bytes) issue_request(OP_RX_BYTE, frame_port, 8'($urandom), 1'b0, '0);
            sent += n_ticks + n_bytes;
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   // receiver ready pattern, switching style whenever the stall counter runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ready_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(4, 80);
      end
      stall_left--;
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_tready <= (stall_left % 3 != 0);
         default:        rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mon_got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t mismatch: result transfer %0h with none expected",
                     $realtime, rsp_tdata);
            mismatches++;
         end else begin
            mon_want = expected_rsp_q.pop_front();
            compare_field("stored", mon_want.stored, mon_got.stored);
            compare_field("overflow_drop", mon_want.overflow_drop, mon_got.overflow_drop);
            compare_field("frame_restart", mon_want.frame_restart, mon_got.frame_restart);
            compare_field("session_reset", mon_want.session_reset, mon_got.session_reset);
            compare_field("byte_index", mon_want.byte_index, mon_got.byte_index);
            compare_field("frame_end_mask", mon_want.frame_end_mask, mon_got.frame_end_mask);
            compare_field("tx_limit_mask", mon_want.tx_limit_mask, mon_got.tx_limit_mask);
            compare_field("tx_done", mon_want.tx_done, mon_got.tx_done);
         end
         bytes_stored   += mon_got.stored;
         drops_seen     += mon_got.overflow_drop;
         frame_starts   += mon_got.frame_restart;
         session_starts += mon_got.session_reset;
         tx_pulses      += mon_got.tx_done;
      end
   end

   // stimulus
   initial begin
      cfg_type    next_cfg;
      int         cur_setting;
      int         gap_span;
      logic [1:0] long_port;

      fixed_settings[S_DEFAULT] = model_cfg;
      fixed_settings[S_ONES]    = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 2'd3};
      fixed_settings[S_ZEROS]   = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0};
      fixed_settings[S_MAX]     = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2};

      // reset thresholds, counters from zero
      directed_rows = '{
         '{S_DEFAULT, OP_TICK,    2'd0, 8'h00, 1'b1, make_result(0, 0, 0, 0, 8'd0, 4'h0, 4'h0, 0)},
         '{S_DEFAULT, OP_RX_BYTE, 2'd0, 8'h00, 1'b1, make_result(1, 0, 0, 0, 8'd0, 4'h0, 4'h0, 0)},
         '{S_DEFAULT, OP_RX_BYTE, 2'd3, 8'hFF, 1'b1, make_result(1, 0, 0, 0, 8'd0, 4'h0, 4'h0, 0)},
         '{S_DEFAULT, OP_RX_BYTE, 2'd3, 8'hAA, 1'b1, make_result(1, 0, 0, 0, 8'd1, 4'h0, 4'h0, 0)},
         '{S_DEFAULT, OP_TX_DONE, 2'd2, 8'h00, 1'b1, make_result(0, 0, 0, 0, 8'd0, 4'h0, 4'h0, 1)},
         '{S_DEFAULT, OP_UNUSED,  2'd1, 8'h55, 1'b1, make_result(0, 0, 0, 0, 8'd0, 4'h0, 4'h0, 0)},
         '{S_DEFAULT, OP_TICK,    2'd0, 8'h00, 1'b0, '0},
         '{S_DEFAULT, OP_TICK,    2'd1, 8'h00, 1'b0, '0},
         '{S_DEFAULT, OP_TICK,    2'd2, 8'h00, 1'b0, '0},
         '{S_DEFAULT, OP_TICK,    2'd3, 8'h00, 1'b0, '0},
         '{S_DEFAULT, OP_RX_BYTE, 2'd1, 8'h80, 1'b0, '0},
         '{S_DEFAULT, OP_RX_BYTE, 2'd2, 8'h01, 1'b0, '0},
         // every threshold at one, radio on the top port
         '{S_ONES,    OP_TICK,    2'd0, 8'h00, 1'b0, '0},
         '{S_ONES,    OP_RX_BYTE, 2'd3, 8'h7F, 1'b0, '0},
         '{S_ONES,    OP_RX_BYTE, 2'd0, 8'hC3, 1'b0, '0},
         '{S_ONES,    OP_RX_BYTE, 2'd0, 8'h3C, 1'b0, '0},
         '{S_ONES,    OP_TX_DONE, 2'd0, 8'h00, 1'b0, '0},
         // zero ceilings: counters frozen, every compare holds
         '{S_ZEROS,   OP_TICK,    2'd0, 8'h00, 1'b1, make_result(0, 0, 0, 0, 8'd0, 4'hF, 4'hF, 0)},
         '{S_ZEROS,   OP_RX_BYTE, 2'd2, 8'hE1, 1'b0, '0},
         '{S_ZEROS,   OP_TX_DONE, 2'd1, 8'h00, 1'b0, '0},
         // top thresholds: nothing ever saturates
         '{S_MAX,     OP_TICK,    2'd0, 8'h00, 1'b1, make_result(0, 0, 0, 0, 8'd0, 4'h0, 4'h0, 0)},
         '{S_MAX,     OP_RX_BYTE, 2'd2, 8'h5A, 1'b0, '0},
         '{S_MAX,     OP_RX_BYTE, 2'd1, 8'hA5, 1'b0, '0},
         '{S_MAX,     OP_TX_DONE, 2'd3, 8'h00, 1'b0, '0},
         '{S_MAX,     OP_UNUSED,  2'd3, 8'hFF, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      cur_setting = S_DEFAULT;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != cur_setting) begin
            settle_block();
            apply_settings(fixed_settings[directed_rows[i].setting]);
            cur_setting = directed_rows[i].setting;
         end
         issue_request(directed_rows[i].op, directed_rows[i].port, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].rsp);
      end

      // random traffic under the extreme settings
      for (int s = S_ONES; s <= S_MAX; s++) begin
         settle_block();
         apply_settings(fixed_settings[s]);
         run_traffic(40, 10);
      end

      // random traffic under random small thresholds
      for (int ph = 0; ph < 5; ph++) begin
         settle_block();
         next_cfg = random_settings();
         apply_settings(next_cfg);
         gap_span = ((next_cfg.session_gap > next_cfg.radio_gap) ? next_cfg.session_gap
                                                                 : next_cfg.radio_gap) + 4;
         // one long run on a single port wraps its buffer at least once
         if (ph == 0) begin
            long_port = 2'($urandom_range(0, 3));
            repeat (BUFFER_BYTES + 4) issue_request(OP_RX_BYTE, long_port, 8'($urandom),
                                                    1'b0, '0);
         end
         run_traffic(60, gap_span);
      end

      settle_block();
      $display("%0d requests over %0d register settings, %0d results checked",
               requests_sent, settings_applied, results_seen);
      $display("%0d bytes stored, %0d overflow drops, %0d frame starts,",
               bytes_stored, drops_seen, frame_starts);
      $display("%0d session starts, %0d tx completions", session_starts, tx_pulses);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
